@@ hw/rtl/mpd_pkg.sv @@
`timescale 1ns / 1ps

package mpd_pkg;

  localparam int VAL_W      = 32;
  localparam int COL_W      = 13;
  localparam int ROW_W      = 16;
  localparam int WIDTH_W    = 14;
  localparam int FACTOR_W   = 7;
  localparam int COUNT_W    = 29;
  localparam int CFG_IDX_W  = 3;
  localparam int FCMP_W     = 9;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_MAX = 14'd8192;

  // fixed no-data sentinels, Q24.8: -32767, -32768, -9999, -99999
  localparam logic [VAL_W-1:0] SENT_A = 32'hFF80_0100;
  localparam logic [VAL_W-1:0] SENT_B = 32'hFF80_0000;
  localparam logic [VAL_W-1:0] SENT_C = 32'hFFD8_F100;
  localparam logic [VAL_W-1:0] SENT_D = 32'hFE79_6100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_FACTOR       = 3'd2,
    REG_USE_NODATA   = 3'd3,
    REG_NODATA_VALUE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
  } pos_t;

  typedef struct packed {
    logic             has;
    logic [VAL_W-1:0] max;
  } cell_t;

endpackage

@@ hw/rtl/mpd_scan.sv @@
`timescale 1ns / 1ps

module mpd_scan import mpd_pkg::*; #(
  parameter int MAX_FACTOR = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [WIDTH_W-1:0]  row_width,
  input  logic [ROW_W-1:0]    frame_height,
  input  logic [FACTOR_W-1:0] factor,
  output pos_t                pos
);

  localparam int CNT_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  logic [COL_W-1:0] pixel_col_r, pixel_col_nxt;
  logic [ROW_W-1:0] pixel_row_r, pixel_row_nxt;
  logic [CNT_W-1:0] col_in_block_r, col_in_block_nxt;
  logic [CNT_W-1:0] row_in_block_r, row_in_block_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;

  logic [WIDTH_W-1:0] w_eff;
  logic [ROW_W-1:0]   h_eff;
  logic [FCMP_W-1:0]  f_eff;
  logic               row_end, frame_end, blk_col_end, blk_row_end;

  always_comb begin
    if (row_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (row_width > ROW_WIDTH_MAX) begin
      w_eff = ROW_WIDTH_MAX;
    end else begin
      w_eff = row_width;
    end
    h_eff = (frame_height == '0) ? ROW_W'(1) : frame_height;
    if (factor == '0) begin
      f_eff = FCMP_W'(1);
    end else if (FCMP_W'(factor) > FCMP_W'(MAX_FACTOR)) begin
      f_eff = FCMP_W'(MAX_FACTOR);
    end else begin
      f_eff = FCMP_W'(factor);
    end
  end

  assign row_end     = (WIDTH_W'(pixel_col_r) + WIDTH_W'(1)) >= w_eff;
  assign frame_end   = ((ROW_W+1)'(pixel_row_r) + (ROW_W+1)'(1)) >= (ROW_W+1)'(h_eff);
  assign blk_col_end = ((FCMP_W'(col_in_block_r) + FCMP_W'(1)) >= f_eff) || row_end;
  assign blk_row_end = ((FCMP_W'(row_in_block_r) + FCMP_W'(1)) >= f_eff) || frame_end;

  assign pos.emit    = blk_col_end && blk_row_end;
  assign pos.last    = row_end && frame_end;
  assign pos.out_col = out_col_r;
  assign pos.out_row = out_row_r;

  always_comb begin
    pixel_col_nxt    = pixel_col_r;
    pixel_row_nxt    = pixel_row_r;
    col_in_block_nxt = col_in_block_r;
    row_in_block_nxt = row_in_block_r;
    out_col_nxt      = out_col_r;
    out_row_nxt      = out_row_r;
    if (advance) begin
      if (row_end) begin
        pixel_col_nxt    = '0;
        col_in_block_nxt = '0;
        out_col_nxt      = '0;
        if (frame_end) begin
          pixel_row_nxt    = '0;
          row_in_block_nxt = '0;
          out_row_nxt      = '0;
        end else begin
          pixel_row_nxt = pixel_row_r + ROW_W'(1);
          if (blk_row_end) begin
            row_in_block_nxt = '0;
            out_row_nxt      = out_row_r + ROW_W'(1);
          end else begin
            row_in_block_nxt = row_in_block_r + CNT_W'(1);
          end
        end
      end else begin
        pixel_col_nxt = pixel_col_r + COL_W'(1);
        if (blk_col_end) begin
          col_in_block_nxt = '0;
          out_col_nxt      = out_col_r + COL_W'(1);
        end else begin
          col_in_block_nxt = col_in_block_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_col_r    <= '0;
      pixel_row_r    <= '0;
      col_in_block_r <= '0;
      row_in_block_r <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
    end else begin
      pixel_col_r    <= pixel_col_nxt;
      pixel_row_r    <= pixel_row_nxt;
      col_in_block_r <= col_in_block_nxt;
      row_in_block_r <= row_in_block_nxt;
      out_col_r      <= out_col_nxt;
      out_row_r      <= out_row_nxt;
    end
  end

endmodule

@@ hw/rtl/max_pool_downsample_nodata.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_ready   in_sample, in_not_finite
// out      source     out_valid / out_ready cell value, validity, column, row, last, count
// cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample per clock unless a finished cell waits on a full output register.
// The column store is one 33-bit memory (maximum plus has-value bit), read at acceptance
// and written back at update; the latest write is forwarded to cover the overlap.
// After reset, clearing all MAX_OUT_COLS entries holds in_ready low; cfg is always open.
// With out_ready low one result waits in the output register and one more item in the
// update stage; in_ready falls only when that item also finishes a cell.

module max_pool_downsample_nodata import mpd_pkg::*; #(
  parameter int MAX_OUT_COLS = 8192,
  parameter int MAX_FACTOR   = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VAL_W-1:0] in_sample,
  input  logic                 in_not_finite,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VAL_W-1:0] out_cell_value,
  output logic                 out_cell_valid,
  output logic [COL_W-1:0]     out_cell_col,
  output logic [ROW_W-1:0]     out_cell_row,
  output logic                 out_last_cell,
  output logic [COUNT_W-1:0]   out_valid_cell_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data
);

  localparam int IDX_W = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
  localparam int EXT_W = 17;

  // configuration
  logic [WIDTH_W-1:0]  row_width_r;
  logic [ROW_W-1:0]    frame_height_r;
  logic [FACTOR_W-1:0] factor_r;
  logic                use_nodata_r;
  logic [VAL_W-1:0]    nodata_value_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= WIDTH_W'(1);
      frame_height_r <= ROW_W'(1);
      factor_r       <= FACTOR_W'(1);
      use_nodata_r   <= 1'b0;
      nodata_value_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH:    row_width_r    <= cfg_data[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[ROW_W-1:0];
        REG_FACTOR:       factor_r       <= cfg_data[FACTOR_W-1:0];
        REG_USE_NODATA:   use_nodata_r   <= cfg_data[0];
        REG_NODATA_VALUE: nodata_value_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // acceptance stage
  logic       clr_active_r;
  logic [IDX_W-1:0] clr_addr_r;
  logic       s1_valid_r;
  logic       s1_fire;
  logic       in_fire;
  logic       out_free;
  pos_t       pos;
  logic       is_nodata;
  logic [EXT_W-1:0] col_ext;
  logic [IDX_W-1:0] rd_idx;

  assign in_fire = in_valid && in_ready;

  mpd_scan #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (in_fire),
    .row_width    (row_width_r),
    .frame_height (frame_height_r),
    .factor       (factor_r),
    .pos          (pos)
  );

  always_comb begin
    if (use_nodata_r) begin
      is_nodata = (in_sample == nodata_value_r);
    end else begin
      is_nodata = (in_sample == SENT_A) || (in_sample == SENT_B) ||
                  (in_sample == SENT_C) || (in_sample == SENT_D);
    end
    col_ext = EXT_W'(pos.out_col);
    if (col_ext >= EXT_W'(MAX_OUT_COLS)) begin
      rd_idx = IDX_W'(MAX_OUT_COLS - 1);
    end else begin
      rd_idx = col_ext[IDX_W-1:0];
    end
  end

  // update stage
  logic signed [VAL_W-1:0] s1_sample_r;
  logic             s1_ok_r;
  logic [IDX_W-1:0] s1_idx_r;
  pos_t             s1_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
      s1_ok_r     <= !in_not_finite && !is_nodata;
      s1_idx_r    <= rd_idx;
      s1_pos_r    <= pos;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_pos_r.emit || out_free);
  assign in_ready = !clr_active_r && (!s1_valid_r || s1_fire);

  // column store
  cell_t            mem [MAX_OUT_COLS];
  cell_t            rd_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  cell_t            mem_wdata;
  logic             fwd_valid_r;
  logic [IDX_W-1:0] fwd_idx_r;
  cell_t            fwd_data_r;
  cell_t            cur;
  cell_t            upd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_r <= mem[rd_idx];
    end
  end

  // latest write covers a read issued on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_idx_r  <= mem_waddr;
      fwd_data_r <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      if (clr_addr_r == IDX_W'(MAX_OUT_COLS - 1)) begin
        clr_active_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + IDX_W'(1);
    end
  end

  always_comb begin
    cur = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : rd_r;
    upd.has = cur.has || s1_ok_r;
    if (s1_ok_r && (!cur.has || (s1_sample_r > $signed(cur.max)))) begin
      upd.max = s1_sample_r;
    end else begin
      upd.max = cur.max;
    end
    mem_we = clr_active_r || s1_fire;
    if (clr_active_r) begin
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_waddr     = s1_idx_r;
      mem_wdata.max = upd.max;
      mem_wdata.has = upd.has && !s1_pos_r.emit;
    end
  end

  // result register
  logic [COUNT_W-1:0] valid_total_r;
  logic [COUNT_W-1:0] count_inc;
  logic               out_valid_r;
  logic               emit_fire;

  assign emit_fire = s1_fire && s1_pos_r.emit;
  assign count_inc = valid_total_r + COUNT_W'(upd.has);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_total_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (emit_fire) begin
        valid_total_r <= s1_pos_r.last ? '0 : count_inc;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_cell_value       <= upd.has ? $signed(upd.max) : '0;
      out_cell_valid       <= upd.has;
      out_cell_col         <= s1_pos_r.out_col;
      out_cell_row         <= s1_pos_r.out_row;
      out_last_cell        <= s1_pos_r.last;
      out_valid_cell_count <= count_inc;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/mpd_port_check.sv @@
`timescale 1ns / 1ps

module mpd_port_check import mpd_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [VAL_W-1:0]     out_cell_value,
  input logic                 out_cell_valid,
  input logic [COL_W-1:0]     out_cell_col,
  input logic [ROW_W-1:0]     out_cell_row,
  input logic                 out_last_cell,
  input logic [COUNT_W-1:0]   out_valid_cell_count
);

  // a waiting request keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_value) &&
      $stable(out_cell_valid) && $stable(out_cell_col) && $stable(out_cell_row) &&
      $stable(out_last_cell) && $stable(out_valid_cell_count))
    else $error("result request changed while stalled");

  // empty cells report zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cell_valid |-> out_cell_value == '0)
    else $error("empty cell with non-zero value");

  // clearing pass blocks input right after reset
  a_clear_block: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during column store clear");

  // no result request straight after reset
  a_no_out_in_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result request straight after reset");

endmodule

bind max_pool_downsample_nodata mpd_port_check u_port_check (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_cell_value       (out_cell_value),
  .out_cell_valid       (out_cell_valid),
  .out_cell_col         (out_cell_col),
  .out_cell_row         (out_cell_row),
  .out_last_cell        (out_last_cell),
  .out_valid_cell_count (out_valid_cell_count)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import mpd_pkg::*;

  localparam int MAX_COLS      = 8192;
  localparam int MAX_POOL_EDGE = 64;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic               valid;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last;
    logic [COUNT_W-1:0] count;
  } pooled_cell_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VAL_W-1:0] in_sample = '0;
  logic                    in_not_finite = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_cell_value;
  logic                    out_cell_valid;
  logic [COL_W-1:0]        out_cell_col;
  logic [ROW_W-1:0]        out_cell_row;
  logic                    out_last_cell;
  logic [COUNT_W-1:0]      out_valid_cell_count;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [VAL_W-1:0]        cfg_data = '0;

  // pooling state mirrored from the block
  logic [VAL_W-1:0]   col_max [MAX_COLS];
  bit                 col_has [MAX_COLS];
  logic [COL_W-1:0]   px_col = '0;
  logic [ROW_W-1:0]   px_row = '0;
  logic [5:0]         blk_col = '0;
  logic [5:0]         blk_row = '0;
  logic [COL_W-1:0]   out_col = '0;
  logic [ROW_W-1:0]   out_row = '0;
  logic [COUNT_W-1:0] valid_cells = '0;

  logic [WIDTH_W-1:0]  cfg_w = WIDTH_W'(1);
  logic [ROW_W-1:0]    cfg_h = ROW_W'(1);
  logic [FACTOR_W-1:0] cfg_f = FACTOR_W'(1);
  logic                cfg_use_nd = 1'b0;
  logic [VAL_W-1:0]    cfg_nd = '0;

  pooled_cell_t pooled_cells_due [$];
  pooled_cell_t seen_cell, due_cell;
  int unsigned  cell_errors = 0;
  int unsigned  cycle_count = 0;
  int unsigned  send_idle = 0;
  int unsigned  recv_stall = 0;

  max_pool_downsample_nodata dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample            (in_sample),
    .in_not_finite        (in_not_finite),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_cell_value       (out_cell_value),
    .out_cell_valid       (out_cell_valid),
    .out_cell_col         (out_cell_col),
    .out_cell_row         (out_cell_row),
    .out_last_cell        (out_last_cell),
    .out_valid_cell_count (out_valid_cell_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic fold_sample(input logic [VAL_W-1:0] s, input logic bad);
    int unsigned w, h, f;
    bit row_end, frame_end, col_done, row_done, drop;
    pooled_cell_t done_cell;
    w = (cfg_w == 0) ? 1 : ((cfg_w > ROW_WIDTH_MAX) ? ROW_WIDTH_MAX : cfg_w);
    h = (cfg_h == 0) ? 1 : cfg_h;
    f = (cfg_f == 0) ? 1 : ((cfg_f > MAX_POOL_EDGE) ? MAX_POOL_EDGE : cfg_f);
    row_end   = (px_col + 1 >= w);
    frame_end = (px_row + 1 >= h);
    col_done  = (blk_col + 1 >= f) || row_end;
    row_done  = (blk_row + 1 >= f) || frame_end;
    if (cfg_use_nd)
      drop = bad || (s == cfg_nd);
    else
      drop = bad || s == SENT_A || s == SENT_B || s == SENT_C || s == SENT_D;
    if (!drop) begin
      if (!col_has[out_col] || $signed(s) > $signed(col_max[out_col]))
        col_max[out_col] = s;
      col_has[out_col] = 1'b1;
    end
    if (col_done && row_done) begin
      if (col_has[out_col])
        valid_cells = valid_cells + 1'b1;
      done_cell.value = col_has[out_col] ? col_max[out_col] : '0;
      done_cell.valid = col_has[out_col];
      done_cell.col   = out_col;
      done_cell.row   = out_row;
      done_cell.last  = row_end && frame_end;
      done_cell.count = valid_cells;
      pooled_cells_due.insert(pooled_cells_due.size(), done_cell);
      col_has[out_col] = 1'b0;
    end
    if (row_end) begin
      px_col  = '0;
      blk_col = '0;
      out_col = '0;
      if (frame_end) begin
        px_row      = '0;
        blk_row     = '0;
        out_row     = '0;
        valid_cells = '0;
      end else begin
        px_row = px_row + 1'b1;
        if (row_done) begin
          blk_row = '0;
          out_row = out_row + 1'b1;
        end else begin
          blk_row = blk_row + 1'b1;
        end
      end
    end else begin
      px_col = px_col + 1'b1;
      if (col_done) begin
        blk_col = '0;
        out_col = out_col + 1'b1;
      end else begin
        blk_col = blk_col + 1'b1;
      end
    end
  endtask

  // register writes, then input requests, then result checks
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ROW_WIDTH:    cfg_w = cfg_data[WIDTH_W-1:0];
          REG_FRAME_HEIGHT: cfg_h = cfg_data[ROW_W-1:0];
          REG_FACTOR:       cfg_f = cfg_data[FACTOR_W-1:0];
          REG_USE_NODATA:   cfg_use_nd = cfg_data[0];
          REG_NODATA_VALUE: cfg_nd = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        fold_sample(in_sample, in_not_finite);
      if (out_valid && out_ready) begin
        seen_cell.value = out_cell_value;
        seen_cell.valid = out_cell_valid;
        seen_cell.col   = out_cell_col;
        seen_cell.row   = out_cell_row;
        seen_cell.last  = out_last_cell;
        seen_cell.count = out_valid_cell_count;
        if (pooled_cells_due.size() == 0) begin
          if (cell_errors < 10)
            $display("unexpected cell: value %h valid %b col %0d row %0d last %b count %0d",
                     seen_cell.value, seen_cell.valid, seen_cell.col, seen_cell.row,
                     seen_cell.last, seen_cell.count);
          cell_errors++;
        end else begin
          due_cell = pooled_cells_due.pop_front();
          if (seen_cell.value !== due_cell.value || seen_cell.valid !== due_cell.valid ||
              seen_cell.col !== due_cell.col || seen_cell.row !== due_cell.row ||
              seen_cell.last !== due_cell.last || seen_cell.count !== due_cell.count) begin
            if (cell_errors < 10) begin
              $display("cell mismatch: expected value %h valid %b col %0d row %0d last %b count %0d",
                       due_cell.value, due_cell.valid, due_cell.col, due_cell.row,
                       due_cell.last, due_cell.count);
              $display("               got      value %h valid %b col %0d row %0d last %b count %0d",
                       seen_cell.value, seen_cell.valid, seen_cell.col, seen_cell.row,
                       seen_cell.last, seen_cell.count);
            end
            cell_errors++;
          end
        end
      end
    end
  end

  task automatic push_sample(input logic [VAL_W-1:0] value, input logic bad);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= value;
    in_not_finite <= bad;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off requests until every cell due has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pooled_cells_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [VAL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_config(input int unsigned w, input int unsigned h, input int unsigned f,
                              input logic use_nd, input logic [VAL_W-1:0] nd);
    write_reg(REG_ROW_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_FACTOR, f);
    write_reg(REG_USE_NODATA, VAL_W'(use_nd));
    write_reg(REG_NODATA_VALUE, nd);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] pick_sentinel();
    case ($urandom_range(0, 3))
      0:       return SENT_A;
      1:       return SENT_B;
      2:       return SENT_C;
      default: return SENT_D;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0, 1:    return pick_sentinel();
      2:       return cfg_nd;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return pick_sentinel() + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
      6, 7:    return ($urandom() & 32'h0000_0FFF) |
                      ($urandom_range(0, 1) ? 32'hFFFF_F000 : 32'h0);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_config();
    int unsigned w, h, f;
    logic [VAL_W-1:0] nd;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = ROW_WIDTH_MAX;
      2:       w = 16383;
      3:       w = $urandom_range(25, 300);
      default: w = $urandom_range(1, 24);
    endcase
    case ($urandom_range(0, 9))
      0:       h = 0;
      1:       h = 65535;
      2:       h = $urandom_range(11, 40);
      default: h = $urandom_range(1, 10);
    endcase
    case ($urandom_range(0, 9))
      0:       f = 0;
      1:       f = MAX_POOL_EDGE;
      2:       f = 127;
      3:       f = $urandom_range(7, 63);
      default: f = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 5))
      0:       nd = pick_sentinel();
      1:       nd = 32'h8000_0000;
      2:       nd = 32'h7FFF_FFFF;
      default: nd = $urandom();
    endcase
    write_config(w, h, f, 1'($urandom_range(0, 1)), nd);
  endtask

  task automatic test_reset_defaults();
    push_sample(32'h0000_0100, 1'b0);
    push_sample(SENT_C, 1'b0);
    push_sample(32'h0000_0001, 1'b1);
  endtask

  task automatic test_sentinels();
    drain();
    write_config(4, 2, 2, 1'b0, '0);
    push_sample(SENT_A, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b0);
    push_sample(SENT_B, 1'b0);
    push_sample(SENT_C, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(SENT_D, 1'b0);
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'h0000_0100, 1'b1);
  endtask

  task automatic test_nodata_value();
    drain();
    write_config(2, 2, 2, 1'b1, 32'h8000_0000);
    push_sample(SENT_A, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(SENT_B, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
    // whole frame rejected: invalid cell, zero count
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h8000_0000, 1'b1);
    push_sample(32'h8000_0000, 1'b0);
    push_sample(32'h8000_0000, 1'b0);
  endtask

  task automatic test_zero_config();
    drain();
    write_config(0, 0, 0, 1'b0, '0);
    push_sample(32'hFFFF_FF00, 1'b0);
    push_sample(SENT_D, 1'b0);
    push_sample(32'h0000_0000, 1'b0);
  endtask

  task automatic test_factor_limits();
    drain();
    write_config(130, 1, 127, 1'b1, $urandom());
    repeat (130) push_sample(pick_sample(), $urandom_range(0, 9) == 0);
    drain();
    write_config(5, 3, MAX_POOL_EDGE, 1'b0, '0);
    repeat (15) push_sample(pick_sample(), $urandom_range(0, 9) == 0);
  endtask

  // long row at a saturated width, then limits shrunk below the live counters
  task automatic test_wide_row();
    drain();
    write_config(16383, 65535, 1, 1'b0, '0);
    repeat (200) push_sample(pick_sample(), $urandom_range(0, 9) == 0);
    drain();
    write_config(3, 1, 2, 1'b0, '0);
    repeat (3) push_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input int unsigned items);
    int unsigned left, burst;
    send_idle  = idle;
    recv_stall = stall;
    left = items;
    while (left > 0) begin
      drain();
      random_config();
      burst = $urandom_range(30, 90);
      if (burst > left)
        burst = left;
      repeat (burst) push_sample(pick_sample(), $urandom_range(0, 9) == 0);
      left = left - burst;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_sentinels();
    test_nodata_value();
    test_zero_config();
    test_factor_limits();
    test_wide_row();
    test_random_traffic(0, 0, 200);
    test_random_traffic(49, 0, 200);
    test_random_traffic(0, 49, 200);
    test_random_traffic(37, 37, 200);
    drain();
    if (cell_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
